// ===== design/slfa_pkg.sv =====
// Shared types and constants for the slot free-list allocator.
package slfa_pkg;

  localparam int SLOT_W   = 10;
  localparam int CURSOR_W = 11;
  localparam int CODE_W   = 4;
  localparam int REQ_W    = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_SKIP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic {
    CFG_CAPACITY   = 1'b0,
    CFG_EXHAUSTION = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_out;
    logic                free_dropped;
    logic [CODE_W-1:0]   fail_code;
    logic [SLOT_W-1:0]   slot_out;
    logic                granted;
  } result_t;

endpackage

// ===== design/slfa_stack_ram.sv =====
// Free-slot stack storage: one write port, one registered read port.
module slfa_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [slfa_pkg::SLOT_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [slfa_pkg::SLOT_W-1:0] rdata
);
  import slfa_pkg::*;

  logic [SLOT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/slot_free_list_allocator_core.sv =====
// Slot allocator top level: bump cursor plus LIFO stack of freed slots.
// Results: a pop from the free stack goes through the registered stack RAM
//   read and then the output register; every other request only the latter.
// Throughput: 1 request per cycle while m_tready does not stall the output,
//   except a pop, which holds s_tready low in ST_POP while the RAM read completes.
// Reset: synchronous rst clears cursor, stack count, config and output valid;
//   stack RAM contents are left as they are (only written entries are read).
module slot_free_list_allocator_core #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // config write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [slfa_pkg::CURSOR_W-1:0] cfg_data,
  // request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slfa_pkg::IN_W-1:0]    s_tdata,  // slot_in[9:0], skip_count[20:10]
  input  logic [slfa_pkg::REQ_W-1:0]   s_tuser,  // req_type[1:0]
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slfa_pkg::OUT_W-1:0]   m_tdata   // granted[0], slot_out[10:1],
                                                 // fail_code[14:11], free_dropped[15],
                                                 // cursor_out[26:16]
);
  import slfa_pkg::*;

  localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNTW = $clog2(MAX_SLOTS + 1);
  localparam int CAPW = (CNTW > CURSOR_W) ? CNTW : CURSOR_W;
  localparam logic [CAPW-1:0] MAX_EXT = CAPW'(MAX_SLOTS);
  localparam logic [CNTW-1:0] FULL    = CNTW'(MAX_SLOTS);

  state_t state, state_next;

  logic [CURSOR_W-1:0] slot_capacity;
  logic [CODE_W-1:0]   exhaustion_code;
  logic [CNTW-1:0]     stack_count;
  logic [CURSOR_W-1:0] cursor;
  logic                out_valid;
  result_t             out_data;

  logic                accept;
  logic                pop;
  logic                push;
  logic [CURSOR_W-1:0] cap;
  logic [CURSOR_W:0]   skip_sum;
  logic [SLOT_W-1:0]   slot_in;
  logic [CURSOR_W-1:0] skip_count;
  req_t                req;
  result_t             res;
  logic [CNTW-1:0]     count_next;
  logic [CURSOR_W-1:0] cursor_next;
  logic [SLOT_W-1:0]   rdata;
  logic [AW-1:0]       pop_addr;

  assign cfg_ready  = 1'b1;
  assign req        = req_t'(s_tuser);
  assign slot_in    = s_tdata[SLOT_W-1:0];
  assign skip_count = s_tdata[SLOT_W+CURSOR_W-1:SLOT_W];
  assign accept     = s_tvalid && s_tready;
  assign cap        = ({{(CAPW-CURSOR_W){1'b0}}, slot_capacity} > MAX_EXT) ?
                      MAX_EXT[CURSOR_W-1:0] : slot_capacity;
  assign skip_sum   = {1'b0, cursor} + {1'b0, skip_count};
  assign pop        = accept && (req == REQ_ALLOC) && (stack_count != '0);
  assign push       = accept && (req == REQ_FREE) && ({1'b0, slot_in} < cursor) &&
                      (stack_count != FULL);
  assign pop_addr   = AW'(stack_count - 1'b1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pop) state_next = ST_POP;
      ST_POP:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    case (state)
      ST_IDLE: s_tready = !out_valid || m_tready;
      default: s_tready = 1'b0;
    endcase
  end

  // request evaluation
  always_comb begin
    res         = '0;
    count_next  = stack_count;
    cursor_next = cursor;
    case (req)
      REQ_ALLOC: begin
        if (stack_count != '0) begin
          count_next = stack_count - 1'b1;
        end else if (cursor < cap) begin
          res.granted  = 1'b1;
          res.slot_out = cursor[SLOT_W-1:0];
          cursor_next  = cursor + 1'b1;
        end else begin
          res.fail_code = exhaustion_code;
        end
      end
      REQ_FREE: begin
        if ({1'b0, slot_in} < cursor) begin
          if (stack_count != FULL) begin
            count_next = stack_count + 1'b1;
          end else begin
            res.free_dropped = 1'b1;
          end
        end
      end
      REQ_SKIP: begin
        cursor_next = (skip_sum > {1'b0, cap}) ? cap : skip_sum[CURSOR_W-1:0];
      end
      REQ_CLEAR: begin
        cursor_next = '0;
        count_next  = '0;
      end
      default: ;
    endcase
    res.cursor_out = cursor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      slot_capacity   <= '0;
      exhaustion_code <= '0;
      stack_count     <= '0;
      cursor          <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_CAPACITY:   slot_capacity   <= cfg_data;
          CFG_EXHAUSTION: exhaustion_code <= cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        stack_count <= count_next;
        cursor      <= cursor_next;
      end
      if (accept && !pop) begin
        out_valid <= 1'b1;
      end else if (state == ST_POP) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !pop) begin
      out_data <= res;
    end else if (state == ST_POP) begin
      out_data <= '{cursor_out: cursor, free_dropped: 1'b0, fail_code: '0,
                    slot_out: rdata, granted: 1'b1};
    end
  end

  slfa_stack_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (stack_count[AW-1:0]),
    .wdata (slot_in),
    .re    (pop),
    .raddr (pop_addr),
    .rdata (rdata)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W-$bits(result_t)){1'b0}}, out_data};

endmodule

// ===== design/slfa_checker.sv =====
// Port-level checks for the slot allocator, bound to the top level.
module slfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [slfa_pkg::REQ_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [slfa_pkg::OUT_W-1:0]  m_tdata
);
  import slfa_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_CLEAR) |=>
      m_tvalid && (r.cursor_out == '0) && !r.granted)
    else $error("clear did not report a zero cursor");

  a_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_FREE) |=>
      m_tvalid && !r.granted && (r.fail_code == '0) && (r.slot_out == '0))
    else $error("free request reported a grant or failure");

endmodule

bind slot_free_list_allocator_core slfa_checker u_chk (.*);

// ===== dv/slot_free_list_allocator_core_tb.sv =====
// Self-checking testbench for the slot free-list allocator core.
module slot_free_list_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slfa_pkg::*;

  localparam int          SLOTS     = 1024;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam int          HOLD_LEN  = 300;

  class alloc_scoreboard;
    logic [CURSOR_W-1:0] capacity;
    logic [CODE_W-1:0]   exhaust_code;
    logic [SLOT_W-1:0]   freed [SLOTS];
    int unsigned         freed_count;
    int unsigned         cursor;
    result_t             pending_results [$];
    int unsigned         bad_results;

    function new();
      capacity     = '0;
      exhaust_code = '0;
      freed_count  = 0;
      cursor       = 0;
      bad_results  = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CURSOR_W-1:0] val);
      if (idx == CFG_CAPACITY) begin
        capacity = val;
      end else begin
        exhaust_code = val[CODE_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_request(req_t kind, logic [SLOT_W-1:0] slot,
                               logic [CURSOR_W-1:0] count);
      result_t     r;
      int unsigned cap;
      r   = '0;
      cap = (capacity > SLOTS) ? SLOTS : capacity;
      case (kind)
        REQ_ALLOC: begin
          if (freed_count > 0) begin
            freed_count--;
            r.slot_out = freed[freed_count];
            r.granted  = 1'b1;
          end else if (cursor < cap) begin
            r.slot_out = SLOT_W'(cursor);
            cursor++;
            r.granted  = 1'b1;
          end else begin
            r.fail_code = exhaust_code;
          end
        end
        REQ_FREE: begin
          if (slot < cursor) begin
            if (freed_count < SLOTS) begin
              freed[freed_count] = slot;
              freed_count++;
            end else begin
              r.free_dropped = 1'b1;
            end
          end
        end
        REQ_SKIP: begin
          cursor = (cursor + count > cap) ? cap : cursor + count;
        end
        default: begin
          cursor      = 0;
          freed_count = 0;
        end
      endcase
      r.cursor_out = CURSOR_W'(cursor);
      pending_results = {pending_results, r};
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      result_t exp;
      result_t got;
      got = result_t'(word[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result word=%h", word);
        return;
      end
      exp = pending_results.pop_front();
      if (word !== {{(OUT_W-$bits(result_t)){1'b0}}, exp}) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("result mismatch: exp granted=%0d slot=%0d code=%0d dropped=%0d cursor=%0d",
                   exp.granted, exp.slot_out, exp.fail_code, exp.free_dropped,
                   exp.cursor_out);
          $display("  got word=%h granted=%0d slot=%0d code=%0d dropped=%0d cursor=%0d",
                   word, got.granted, got.slot_out, got.fail_code,
                   got.free_dropped, got.cursor_out);
        end
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [CURSOR_W-1:0]  cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic [REQ_W-1:0]     s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  alloc_scoreboard      sb = new();
  bit                   sender_gapless = 1'b0;
  bit                   long_hold = 1'b0;
  int unsigned          cycles = 0;

  slot_free_list_allocator_core #(
    .MAX_SLOTS (SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SLOT_W-1:0] rnd_slot();
    return SLOT_W'($urandom);
  endfunction

  function automatic logic [CURSOR_W-1:0] rnd_count();
    return CURSOR_W'($urandom);
  endfunction

  // Handshakes are judged at the falling edge, where every signal is settled.
  always @(negedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);

  // Called at a rising edge; returns at the rising edge that takes the request.
  task automatic send_request(req_t kind, logic [SLOT_W-1:0] slot,
                              logic [CURSOR_W-1:0] count);
    int unsigned gap;
    gap = sender_gapless ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_W-SLOT_W-CURSOR_W){1'b0}}, count, slot};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    sb.note_request(kind, slot, count);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CURSOR_W-1:0] val);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // extra idle margin before the config write
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    req_t                kind;
    logic [SLOT_W-1:0]   slot;
    logic [CURSOR_W-1:0] count;
    int unsigned         roll;
    repeat (n) begin
      roll  = $urandom_range(0, 99);
      slot  = rnd_slot();
      count = rnd_count();
      if (roll < 45) begin
        kind = REQ_ALLOC;
      end else if (roll < 80) begin
        kind = REQ_FREE;
        if (sb.cursor > 0 && $urandom_range(0, 9) < 8)
          slot = SLOT_W'($urandom_range(0, sb.cursor - 1));
      end else if (roll < 97) begin
        kind = REQ_SKIP;
        roll = $urandom_range(0, 19);
        if (roll < 16) count = CURSOR_W'($urandom_range(0, 8));
        else if (roll == 19) count = {CURSOR_W{1'b1}};
      end else begin
        kind = REQ_CLEAR;
      end
      send_request(kind, slot, count);
    end
  endtask

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("slot_free_list_allocator_core verification failed");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = HOLD_LEN;
        run_left   = 0;
      end else if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 9) < 6) run_left = $urandom_range(1, 40);
        else stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin : stimulus
    logic [CURSOR_W-1:0] cap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero capacity straight out of reset
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    write_reg(CFG_CAPACITY, 11'd4);
    write_reg(CFG_EXHAUSTION, 11'd15);
    repeat (5) send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    // free above the cursor, then LIFO reuse
    send_request(REQ_FREE, 10'd1023, rnd_count());
    send_request(REQ_FREE, 10'd2, rnd_count());
    send_request(REQ_FREE, 10'd0, rnd_count());
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    send_request(REQ_SKIP, rnd_slot(), 11'd0);
    send_request(REQ_CLEAR, rnd_slot(), rnd_count());
    send_request(REQ_FREE, 10'd0, rnd_count());
    send_request(REQ_SKIP, rnd_slot(), 11'd3);
    send_request(REQ_SKIP, rnd_slot(), 11'h7ff);
    // cursor left above a lowered capacity
    write_reg(CFG_CAPACITY, 11'd2);
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    send_request(REQ_SKIP, rnd_slot(), 11'd0);
    // capacity beyond the slot count
    write_reg(CFG_CAPACITY, 11'h7ff);
    write_reg(CFG_EXHAUSTION, 11'd0);
    send_request(REQ_SKIP, rnd_slot(), 11'h7ff);
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    send_request(REQ_FREE, 10'd1023, rnd_count());
    send_request(REQ_ALLOC, rnd_slot(), rnd_count());

    // fill the free stack past its depth
    write_reg(CFG_CAPACITY, 11'd1024);
    write_reg(CFG_EXHAUSTION, 11'd9);
    send_request(REQ_CLEAR, rnd_slot(), rnd_count());
    send_request(REQ_SKIP, rnd_slot(), 11'd1024);
    repeat (SLOTS + 6) send_request(REQ_FREE, rnd_slot(), rnd_count());
    repeat (40) send_request(REQ_ALLOC, rnd_slot(), rnd_count());
    send_request(REQ_CLEAR, rnd_slot(), rnd_count());

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cap = 11'd1024;
        1: cap = 11'd3;
        2: cap = 11'd16;
        3: cap = 11'd0;
        4: cap = 11'h7ff;
        5: cap = 11'd1;
        6: cap = rnd_count();
        default: cap = 11'd1023;
      endcase
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_EXHAUSTION, (phase == 1) ? 11'd15 : CURSOR_W'($urandom_range(0, 15)));
      sender_gapless = (phase == 0 || phase == 2 || phase == 4);
      // hold the result side off so the core backs up into its input
      if (phase == 2) long_hold = 1'b1;
      run_random(15);
    end
    sender_gapless = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.bad_results == 0 && sb.pending() == 0) begin
      $display("slot_free_list_allocator_core verification clean");
    end else begin
      $display("slot_free_list_allocator_core verification failed");
    end
    $finish;
  end

endmodule
